### rtl/pdp_pkg.sv
// ----------------------------------------------------------------------------
// pdp_pkg
// Shared types and constants of the positional dinucleotide profile block.
// ----------------------------------------------------------------------------
`default_nettype none

package pdp_pkg;

  // Profile store geometry
  localparam int unsigned MAX_POSITIONS = 1024;
  localparam int unsigned ADDR_W        = $clog2(MAX_POSITIONS);
  localparam int unsigned COUNT_W       = 32;

  // Sequence bookkeeping widths
  localparam int unsigned POS_W  = 11;
  localparam int unsigned LEN_W  = 11;
  localparam int unsigned BASE_W = 3;
  localparam int unsigned PAT_W  = 2;

  localparam logic [POS_W-1:0]  POSITION_MAX  = 11'd2047;
  localparam logic [LEN_W-1:0]  SEQ_LEN_RESET = 11'd600;
  localparam logic [BASE_W-1:0] BASE_N        = 3'd4;
  localparam logic [BASE_W-1:0] BASE_T        = 3'd3;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  // Result queue
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = FIFO_PTR_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_BASE  = 2'd0,
    CFG_SECOND_BASE = 2'd1,
    CFG_COMPLEMENT  = 2'd2,
    CFG_SEQ_LENGTH  = 2'd3
  } cfg_reg_e;

  typedef enum logic [0:0] {
    FUNC_PUSH = 1'b0,
    FUNC_READ = 1'b1
  } func_e;

  typedef struct packed {
    logic [COUNT_W-1:0] position_count;
    logic [COUNT_W-1:0] sequences_seen;
    logic               overflow_seen;
  } result_t;

endpackage

`default_nettype wire

### rtl/pdp_if.sv
// ----------------------------------------------------------------------------
// pdp_if
// Valid/ready channels of the profile block: items, results, configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface pdp_item_if;
  import pdp_pkg::*;

  logic              valid;
  logic              ready;
  logic [0:0]        func;
  logic [BASE_W-1:0] base;
  logic              last_base;
  logic [ADDR_W-1:0] read_index;

  modport source (output valid, func, base, last_base, read_index, input ready);
  modport sink   (input valid, func, base, last_base, read_index, output ready);
endinterface

interface pdp_result_if;
  import pdp_pkg::*;

  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] position_count;
  logic [COUNT_W-1:0] sequences_seen;
  logic               overflow_seen;

  modport source (output valid, position_count, sequences_seen, overflow_seen,
                  input ready);
  modport sink   (input valid, position_count, sequences_seen, overflow_seen,
                  output ready);
endinterface

interface pdp_cfg_if;
  import pdp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/pdp_ram.sv
// ----------------------------------------------------------------------------
// pdp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pdp_ram #(
  parameter  int unsigned WIDTH = 32,
  parameter  int unsigned DEPTH = 1024,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/pdp_out_fifo.sv
// ----------------------------------------------------------------------------
// pdp_out_fifo
// Small result queue that decouples the counter pipeline from the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module pdp_out_fifo (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  pdp_pkg::result_t           push_data_i,
  input  logic                       pop_i,
  output pdp_pkg::result_t           head_o,
  output logic [pdp_pkg::FIFO_CNT_W-1:0] count_o
);
  import pdp_pkg::*;

  result_t               store_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] count_q, count_d;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + FIFO_PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + FIFO_PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + FIFO_CNT_W'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Hold entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o  = store_q[rd_ptr_q];
  assign count_o = count_q;

  // Checks
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q != FIFO_CNT_W'(FIFO_DEPTH)) || pop_i)
    else $error("result queue overrun");

  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("result queue underrun");

endmodule

`default_nettype wire

### rtl/positional_dinucleotide_profile_core.sv
// ----------------------------------------------------------------------------
// positional_dinucleotide_profile_core
// Counts a configured dinucleotide per start position over aligned sequences.
// ----------------------------------------------------------------------------
// After reset the block sweeps its 1024-entry counter RAM to zero, one entry
// per cycle, and the item channel stays not-ready until the sweep is done
// (configuration writes are taken throughout). From then on one item, push or
// read, is taken every cycle unless stalled: a push does a read-modify-write
// of one counter through a two-stage pipeline (RAM read, then increment and
// write back, with a one-entry bypass for back-to-back hits on the same
// position); a read passes its count from the registered RAM read data on.
// A four-entry result queue absorbs output stalls, and the item channel
// stalls only when that queue, together with a read in flight, is full.
`default_nettype none

module positional_dinucleotide_profile_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  pdp_item_if.sink     item_i,
  pdp_result_if.source result_o,
  pdp_cfg_if.sink      cfg_i
);
  import pdp_pkg::*;

  // Clamp to N and optionally complement one base
  function automatic logic [BASE_W-1:0] prep_base(input logic [BASE_W-1:0] raw,
                                                  input logic              cmp);
    logic [BASE_W-1:0] b;
    b = (raw > BASE_N) ? BASE_N : raw;
    if (cmp && (b != BASE_N)) begin
      b = BASE_T - b;
    end
    return b;
  endfunction

  // Configuration registers
  logic [PAT_W-1:0] first_base_q, second_base_q;
  logic             complement_q;
  logic [LEN_W-1:0] seq_len_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_base_q  <= '0;
      second_base_q <= '0;
      complement_q  <= 1'b0;
      seq_len_q     <= SEQ_LEN_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        CFG_FIRST_BASE:  first_base_q  <= cfg_i.data[PAT_W-1:0];
        CFG_SECOND_BASE: second_base_q <= cfg_i.data[PAT_W-1:0];
        CFG_COMPLEMENT:  complement_q  <= cfg_i.data[0];
        CFG_SEQ_LENGTH:  seq_len_q     <= cfg_i.data[LEN_W-1:0];
        default:         ;
      endcase
    end
  end

  // Clearing sweep after reset
  logic              clr_active_q;
  logic [ADDR_W-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
    end else if (clr_active_q) begin
      clr_addr_q <= clr_addr_q + ADDR_W'(1);
      if (clr_addr_q == ADDR_W'(MAX_POSITIONS - 1)) begin
        clr_active_q <= 1'b0;
      end
    end
  end

  // Sequence state
  logic [BASE_W-1:0]  prev_base_q, prev_base_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [COUNT_W-1:0] seq_total_q, seq_total_d;
  logic               overflow_q, overflow_d;

  // Stage 1 and result queue
  logic               s1_valid_q, s1_read_q, s1_inc_q;
  logic [ADDR_W-1:0]  s1_addr_q;
  logic [COUNT_W-1:0] s1_seq_q;
  logic               s1_ovf_q;
  logic [FIFO_CNT_W-1:0] fifo_count;
  logic [FIFO_CNT_W-1:0] pending;
  result_t            fifo_head, fifo_push_data;
  logic               fifo_push, fifo_pop;

  // Stage 0 decode
  logic              accept, is_read, is_push;
  logic [BASE_W-1:0] cur_base;
  logic [POS_W-1:0]  start_pos;
  logic [LEN_W-1:0]  eff_len;
  logic              win_valid, in_range, pat_hit, inc_hit, ovf_hit;
  logic [ADDR_W-1:0] ram_raddr;

  assign pending      = fifo_count + FIFO_CNT_W'(s1_valid_q && s1_read_q);
  assign item_i.ready = !clr_active_q && (pending < FIFO_CNT_W'(FIFO_DEPTH));
  assign accept       = item_i.valid && item_i.ready;
  assign is_read      = func_e'(item_i.func) == FUNC_READ;
  assign is_push      = accept && !is_read;

  assign cur_base  = prep_base(item_i.base, complement_q);
  assign start_pos = pos_q - POS_W'(1);
  assign eff_len   = (seq_len_q > LEN_W'(MAX_POSITIONS)) ? LEN_W'(MAX_POSITIONS)
                                                          : seq_len_q;
  assign win_valid = pos_q != '0;
  assign in_range  = LEN_W'(start_pos) < eff_len;
  assign pat_hit   = (prev_base_q == {1'b0, first_base_q}) &&
                     (cur_base == {1'b0, second_base_q});
  assign inc_hit   = win_valid && in_range && pat_hit;
  assign ovf_hit   = win_valid && !in_range;
  assign ram_raddr = is_read ? item_i.read_index : start_pos[ADDR_W-1:0];

  // Update sequence state on a push transfer
  always_comb begin
    prev_base_d = prev_base_q;
    pos_d       = pos_q;
    seq_total_d = seq_total_q;
    overflow_d  = overflow_q;
    if (is_push) begin
      overflow_d = overflow_q | ovf_hit;
      if (item_i.last_base) begin
        prev_base_d = '0;
        pos_d       = '0;
        if (seq_total_q != '1) begin
          seq_total_d = seq_total_q + COUNT_W'(1);
        end
      end else begin
        prev_base_d = cur_base;
        if (pos_q != POSITION_MAX) begin
          pos_d = pos_q + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_base_q <= '0;
      pos_q       <= '0;
      seq_total_q <= '0;
      overflow_q  <= 1'b0;
    end else begin
      prev_base_q <= prev_base_d;
      pos_q       <= pos_d;
      seq_total_q <= seq_total_d;
      overflow_q  <= overflow_d;
    end
  end

  // Stage 1 control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_read_q  <= 1'b0;
      s1_inc_q   <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      s1_read_q  <= is_read;
      s1_inc_q   <= !is_read && inc_hit;
    end
  end

  // Stage 1 payload, snapshot of totals as seen by a read
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_addr_q <= ram_raddr;
      s1_seq_q  <= seq_total_q;
      s1_ovf_q  <= overflow_q;
    end
  end

  // Counter RAM with last-write bypass
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [COUNT_W-1:0] ram_wdata, ram_rdata;
  logic               wr_valid_q;
  logic [ADDR_W-1:0]  wr_addr_q;
  logic [COUNT_W-1:0] wr_data_q;
  logic [COUNT_W-1:0] cur_cnt, next_cnt;

  assign cur_cnt   = (wr_valid_q && (wr_addr_q == s1_addr_q)) ? wr_data_q : ram_rdata;
  assign next_cnt  = (cur_cnt == '1) ? cur_cnt : cur_cnt + COUNT_W'(1);
  assign ram_we    = clr_active_q || (s1_valid_q && s1_inc_q);
  assign ram_waddr = clr_active_q ? clr_addr_q : s1_addr_q;
  assign ram_wdata = clr_active_q ? '0 : next_cnt;

  pdp_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (MAX_POSITIONS)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_valid_q <= 1'b0;
    end else begin
      wr_valid_q <= ram_we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      wr_addr_q <= ram_waddr;
      wr_data_q <= ram_wdata;
    end
  end

  // Queue read results toward the output
  assign fifo_push                     = s1_valid_q && s1_read_q;
  assign fifo_push_data.position_count = cur_cnt;
  assign fifo_push_data.sequences_seen = s1_seq_q;
  assign fifo_push_data.overflow_seen  = s1_ovf_q;
  assign fifo_pop                      = result_o.valid && result_o.ready;

  pdp_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fifo_push),
    .push_data_i (fifo_push_data),
    .pop_i       (fifo_pop),
    .head_o      (fifo_head),
    .count_o     (fifo_count)
  );

  assign result_o.valid          = fifo_count != '0;
  assign result_o.position_count = fifo_head.position_count;
  assign result_o.sequences_seen = fifo_head.sequences_seen;
  assign result_o.overflow_seen  = fifo_head.overflow_seen;

  // Checks
  a_no_item_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !clr_active_q)
    else $error("item transfer during clearing sweep");

  a_clear_idle_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_active_q |-> !s1_valid_q)
    else $error("pipeline busy during clearing sweep");

  a_overflow_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    overflow_q |=> overflow_q)
    else $error("overflow flag dropped");

  a_inc_only_on_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_inc_q) |-> !s1_read_q)
    else $error("counter update tagged on a read");

endmodule

`default_nettype wire
